### rtl/dcmss_pkg.sv
// Constants, codes and lookup tables shared by the soft-start motor drive.
package dcmss_pkg;

    // Duty resolution and ramp length
    localparam int DUTY_BITS   = 10;
    localparam int RAMP_STEPS  = 20;
    localparam int STEP_W      = $clog2(RAMP_STEPS + 1);
    localparam int DUTY_FULL_I = (1 << DUTY_BITS) - 1;
    localparam logic [DUTY_BITS-1:0] DUTY_FULL = DUTY_BITS'(DUTY_FULL_I);

    // Cosine ease table: 0.5*(1-cos(pi*k/20)) in Q1.16, truncated, k = 1..20
    localparam int EASE_POINTS = 20;
    localparam int EASE_W      = 17;
    localparam int EASE_IDX_W  = $clog2(EASE_POINTS);
    typedef logic [EASE_W-1:0] ease_tab_t [EASE_POINTS];
    localparam ease_tab_t EASE_Q16 = '{
        17'd403,   17'd1603,  17'd3571,  17'd6258,  17'd9597,
        17'd13507, 17'd17891, 17'd22642, 17'd27641, 17'd32768,
        17'd37894, 17'd42893, 17'd47644, 17'd52028, 17'd55938,
        17'd59277, 17'd61964, 17'd63932, 17'd65132, 17'd65536
    };

    // Percent limits
    localparam int PCT_MAX_I = 100;
    localparam int PCT_W     = 7;
    localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(PCT_MAX_I);

    // Input opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_DRIVE = 1'b1;

    // Drive commands; codes above turn right act as stop
    localparam logic [2:0] CMD_STOP  = 3'd0;
    localparam logic [2:0] CMD_FWD   = 3'd1;
    localparam logic [2:0] CMD_REV   = 3'd2;
    localparam logic [2:0] CMD_LEFT  = 3'd3;
    localparam logic [2:0] CMD_RIGHT = 3'd4;

    // Channel enables, bit 0 left fwd, 1 left rev, 2 right fwd, 3 right rev
    localparam logic [3:0] EN_FWD   = 4'b0101;
    localparam logic [3:0] EN_REV   = 4'b1010;
    localparam logic [3:0] EN_LEFT  = 4'b0100;
    localparam logic [3:0] EN_RIGHT = 4'b0001;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_ADDR_W-1:0] CFG_FLOOR_PCT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_COAST     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DM_TMO    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_DM_PERIOD = 3'd4;

    // Register reset values
    localparam logic [PCT_W-1:0] RST_FLOOR_PCT = 7'd65;
    localparam logic [7:0]       RST_ACCEL     = 8'd15;
    localparam logic [7:0]       RST_COAST     = 8'd80;
    localparam logic [11:0]      RST_DM_TMO    = 12'd800;
    localparam logic [9:0]       RST_DM_PERIOD = 10'd100;
    localparam logic [11:0]      IDLE_SAT      = 12'hFFF;

    // Percent to duty: p * full / 100, truncated
    typedef logic [DUTY_BITS-1:0] pct_duty_tab_t [PCT_MAX_I + 1];

    function automatic pct_duty_tab_t build_pct_duty();
        pct_duty_tab_t t;
        for (int p = 0; p <= PCT_MAX_I; p++) begin
            t[p] = DUTY_BITS'((p * DUTY_FULL_I) / 100);
        end
        return t;
    endfunction

    localparam pct_duty_tab_t PCT_DUTY = build_pct_duty();

    // Ramp step to ease point index: ceil(s*20/RAMP_STEPS) - 1, clamped
    typedef logic [EASE_IDX_W-1:0] step_point_tab_t [2**STEP_W];

    function automatic step_point_tab_t build_step_points();
        step_point_tab_t t;
        int idx;
        for (int s = 0; s < 2**STEP_W; s++) begin
            idx = (s * EASE_POINTS + RAMP_STEPS - 1) / RAMP_STEPS;
            if (idx < 1) idx = 1;
            if (idx > EASE_POINTS) idx = EASE_POINTS;
            t[s] = EASE_IDX_W'(idx - 1);
        end
        return t;
    endfunction

    localparam step_point_tab_t STEP_POINT = build_step_points();

    // Stream widths
    localparam int S_TDATA_W = 16;
    localparam int M_FIELD_W = 4 * DUTY_BITS + 5;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

endpackage

### rtl/dc_motor_soft_start_drive.sv
// Soft-start drive for two H-bridge motors: command stream in, duty stream out.
//
// Input stream (s_*): one transaction is either a 1 ms tick (s_tuser = 0) or
// a drive command (s_tuser = 1) with command code and speed percent in tdata.
// Output stream (m_*): exactly one transaction per input transaction, in
// order, carrying the four channel duties and the status after that item.
// Configuration (cfg_*): register writes, always ready; write only while
// the block is idle.
//
// An item in the input register has its result on m_tdata once it moves into
// the state/result register. Throughput: one item per cycle while the receiver
// does not stall; the input and state/result registers form a two-stage
// pipeline, so a new item is taken while a result waits. The ramp arithmetic
// (one table lookup, one 10 x 17 multiply and an add) sits between them.
//
// Reset (aresetn low, synchronous): configuration returns to its defaults,
// all duties go to zero, the sequence is idle and no result is pending.
// When the receiver stalls, one result and one further input item are held;
// s_tready then drops until the result is taken.
module dc_motor_soft_start_drive (
    input  logic                              aclk,
    input  logic                              aresetn,
    // tdata: command [2:0], speed [10:3], zero fill
    input  logic [dcmss_pkg::S_TDATA_W-1:0]   s_tdata,
    // tuser: opcode [0]
    input  logic [0:0]                        s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: left forward duty [9:0], left reverse duty [19:10],
    //        right forward duty [29:20], right reverse duty [39:30],
    //        busy_res [40], active [41], current_command [44:42], zero fill
    output logic [dcmss_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dcmss_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [dcmss_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import dcmss_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_COAST,
        PH_LEFT,
        PH_RIGHT
    } phase_t;

    typedef logic [DUTY_BITS-1:0] duty_t;

    // Configuration registers
    logic [7:0]           accel_reg;
    logic [7:0]           coast_reg;
    logic [11:0]          dm_tmo_reg;
    logic [9:0]           dm_period_reg;
    duty_t                floor_max_reg, floor_max_next;

    // Input stage
    logic                 in_valid_reg;
    logic                 in_opcode_reg;
    logic [2:0]           in_command_reg;
    logic [7:0]           in_speed_reg;

    // Drive state, which is also the result register
    logic                 out_valid_reg;
    logic [2:0]           cmd_reg, cmd_next;
    logic [7:0]           speed_reg, speed_next;
    logic                 active_reg, active_next;
    logic [11:0]          idle_reg, idle_next;
    logic [9:0]           check_reg, check_next;
    phase_t               phase_reg, phase_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [7:0]           wait_reg, wait_next;
    duty_t                duty_reg [4];
    duty_t                duty_next [4];
    duty_t                target_reg, target_next;
    duty_t                floor_reg, floor_next;
    logic [3:0]           enable_reg, enable_next;

    // Working signals
    logic                 proc;
    logic                 cmd_is_stop;
    logic [PCT_W-1:0]     speed_clamp;
    logic [PCT_W-1:0]     cfg_pct;
    duty_t                new_target, new_floor;
    logic [3:0]           new_enable;
    duty_t                lvl_target, lvl_floor, lvl_diff, level;
    logic [STEP_W-1:0]    lvl_step;
    logic [DUTY_BITS+EASE_W-1:0] lvl_prod;
    logic [DUTY_BITS:0]   lvl_sum;
    logic [3:0]           wr_en;
    logic [7:0]           step_gap, wait_dec;
    logic [9:0]           dm_period, check_inc;
    logic [11:0]          idle_inc;

    // Handshakes: the input register refills as it drains
    assign proc      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;

    // Pack the result from the state registers
    assign m_tdata = {{(M_TDATA_W - M_FIELD_W){1'b0}}, cmd_reg, active_reg,
                      (phase_reg != PH_IDLE), duty_reg[3], duty_reg[2],
                      duty_reg[1], duty_reg[0]};

    // Floor limit follows the floor percent register, clamped to 100
    assign cfg_pct        = cfg_wdata[PCT_W-1:0] > PCT_MAX ? PCT_MAX : cfg_wdata[PCT_W-1:0];
    assign floor_max_next = PCT_DUTY[cfg_pct];

    // Decode a drive command into target, floor and enables
    always_comb begin
        cmd_is_stop = (in_command_reg == CMD_STOP) || (in_command_reg > CMD_RIGHT);
        speed_clamp = in_speed_reg > 8'(PCT_MAX) ? PCT_MAX : in_speed_reg[PCT_W-1:0];
        unique case (in_command_reg)
            CMD_FWD:   new_enable = EN_FWD;
            CMD_REV:   new_enable = EN_REV;
            CMD_LEFT:  new_enable = EN_LEFT;
            CMD_RIGHT: new_enable = EN_RIGHT;
            default:   new_enable = 4'b0000;
        endcase
        if (in_command_reg == CMD_FWD || in_command_reg == CMD_REV) begin
            new_target = PCT_DUTY[speed_clamp];
        end else begin
            new_target = DUTY_FULL;
        end
        new_floor = new_target < floor_max_reg ? new_target : floor_max_reg;
    end

    // Ramp level for the step that this item writes
    always_comb begin
        if (in_opcode_reg == OP_DRIVE) begin
            lvl_target = new_target;
            lvl_floor  = new_floor;
            lvl_step   = STEP_W'(1);
            wr_en      = new_enable;
        end else begin
            lvl_target = target_reg;
            lvl_floor  = floor_reg;
            wr_en      = enable_reg;
            unique case (phase_reg)
                PH_LEFT:  lvl_step = step_reg;
                PH_RIGHT: lvl_step = step_reg + STEP_W'(1);
                default:  lvl_step = STEP_W'(1);
            endcase
        end
        lvl_diff = lvl_target - lvl_floor;
        lvl_prod = {{EASE_W{1'b0}}, lvl_diff} *
                   {{DUTY_BITS{1'b0}}, EASE_Q16[STEP_POINT[lvl_step]]};
        lvl_sum  = {1'b0, lvl_floor} + {1'b0, lvl_prod[DUTY_BITS+15:16]};
        level    = lvl_sum[DUTY_BITS-1:0];
    end

    // Timer helpers
    assign step_gap  = accel_reg == 8'd0 ? 8'd1 : accel_reg;
    assign dm_period = dm_period_reg == 10'd0 ? 10'd1 : dm_period_reg;
    assign wait_dec  = wait_reg != 8'd0 ? wait_reg - 8'd1 : 8'd0;
    assign idle_inc  = idle_reg != IDLE_SAT ? idle_reg + 12'd1 : idle_reg;
    assign check_inc = check_reg + 10'd1;

    // Next drive state for the item in the input register
    always_comb begin
        cmd_next    = cmd_reg;
        speed_next  = speed_reg;
        active_next = active_reg;
        idle_next   = idle_reg;
        check_next  = check_reg;
        phase_next  = phase_reg;
        step_next   = step_reg;
        wait_next   = wait_reg;
        target_next = target_reg;
        floor_next  = floor_reg;
        enable_next = enable_reg;
        for (int k = 0; k < 4; k++) begin
            duty_next[k] = duty_reg[k];
        end

        if (in_opcode_reg == OP_DRIVE) begin
            if (cmd_is_stop) begin
                // Stop: drop everything
                active_next = 1'b0;
                cmd_next    = CMD_STOP;
                speed_next  = 8'd0;
                phase_next  = PH_IDLE;
                wait_next   = 8'd0;
                step_next   = '0;
                for (int k = 0; k < 4; k++) duty_next[k] = '0;
            end else begin
                idle_next   = 12'd0;
                active_next = 1'b1;
                if (in_command_reg != cmd_reg || in_speed_reg != speed_reg) begin
                    cmd_next    = in_command_reg;
                    speed_next  = in_speed_reg;
                    target_next = new_target;
                    floor_next  = new_floor;
                    enable_next = new_enable;
                    priority if (new_target == '0) begin
                        // Zero target: all off, no ramp
                        for (int k = 0; k < 4; k++) duty_next[k] = '0;
                        phase_next = PH_IDLE;
                        wait_next  = 8'd0;
                        step_next  = '0;
                    end else if (cmd_reg != CMD_STOP && cmd_reg != in_command_reg &&
                                 coast_reg != 8'd0) begin
                        // Direction change with coast
                        for (int k = 0; k < 4; k++) duty_next[k] = '0;
                        phase_next = PH_COAST;
                        wait_next  = coast_reg;
                        step_next  = '0;
                    end else begin
                        // Start the ramp on the left pair
                        if (cmd_reg != CMD_STOP && cmd_reg != in_command_reg) begin
                            duty_next[2] = '0;
                            duty_next[3] = '0;
                        end
                        duty_next[0] = wr_en[0] ? level : '0;
                        duty_next[1] = wr_en[1] ? level : '0;
                        step_next    = STEP_W'(1);
                        phase_next   = PH_LEFT;
                        wait_next    = step_gap;
                    end
                end
            end
        end else begin
            idle_next = idle_inc;
            // Advance the ramp when its wait runs out
            if (phase_reg != PH_IDLE) begin
                wait_next = wait_dec;
                if (wait_dec == 8'd0) begin
                    unique case (phase_reg)
                        PH_COAST: begin
                            duty_next[0] = wr_en[0] ? level : '0;
                            duty_next[1] = wr_en[1] ? level : '0;
                            step_next    = STEP_W'(1);
                            phase_next   = PH_LEFT;
                            wait_next    = step_gap;
                        end
                        PH_LEFT: begin
                            duty_next[2] = wr_en[2] ? level : '0;
                            duty_next[3] = wr_en[3] ? level : '0;
                            phase_next   = PH_RIGHT;
                            wait_next    = step_gap;
                        end
                        PH_RIGHT: begin
                            if (step_reg >= STEP_W'(RAMP_STEPS)) begin
                                for (int k = 0; k < 4; k++) begin
                                    duty_next[k] = wr_en[k] ? target_reg : '0;
                                end
                                phase_next = PH_IDLE;
                                wait_next  = 8'd0;
                            end else begin
                                duty_next[0] = wr_en[0] ? level : '0;
                                duty_next[1] = wr_en[1] ? level : '0;
                                step_next    = step_reg + STEP_W'(1);
                                phase_next   = PH_LEFT;
                                wait_next    = step_gap;
                            end
                        end
                        default: begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            // Deadman check
            check_next = check_inc;
            if (check_inc >= dm_period) begin
                check_next = 10'd0;
                if (active_reg && idle_inc >= dm_tmo_reg) begin
                    active_next = 1'b0;
                    cmd_next    = CMD_STOP;
                    speed_next  = 8'd0;
                    phase_next  = PH_IDLE;
                    wait_next   = 8'd0;
                    step_next   = '0;
                    for (int k = 0; k < 4; k++) duty_next[k] = '0;
                end
            end
        end
    end

    // Hold configuration, input stage and drive state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_reg     <= RST_ACCEL;
            coast_reg     <= RST_COAST;
            dm_tmo_reg    <= RST_DM_TMO;
            dm_period_reg <= RST_DM_PERIOD;
            floor_max_reg <= PCT_DUTY[RST_FLOOR_PCT];
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cmd_reg       <= CMD_STOP;
            speed_reg     <= 8'd0;
            active_reg    <= 1'b0;
            idle_reg      <= 12'd0;
            check_reg     <= 10'd0;
            phase_reg     <= PH_IDLE;
            step_reg      <= '0;
            wait_reg      <= 8'd0;
            target_reg    <= '0;
            floor_reg     <= '0;
            enable_reg    <= 4'b0000;
            for (int k = 0; k < 4; k++) duty_reg[k] <= '0;
        end else begin
            // Register writes
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_addr)
                    CFG_FLOOR_PCT: floor_max_reg <= floor_max_next;
                    CFG_ACCEL:     accel_reg     <= cfg_wdata[7:0];
                    CFG_COAST:     coast_reg     <= cfg_wdata[7:0];
                    CFG_DM_TMO:    dm_tmo_reg    <= cfg_wdata[11:0];
                    CFG_DM_PERIOD: dm_period_reg <= cfg_wdata[9:0];
                    default: ;
                endcase
            end

            // Input stage
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (s_tvalid && s_tready) begin
                in_opcode_reg  <= s_tuser[0];
                in_command_reg <= s_tdata[2:0];
                in_speed_reg   <= s_tdata[10:3];
            end

            // Result valid
            if (proc) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            // State update
            if (proc) begin
                cmd_reg    <= cmd_next;
                speed_reg  <= speed_next;
                active_reg <= active_next;
                idle_reg   <= idle_next;
                check_reg  <= check_next;
                phase_reg  <= phase_next;
                step_reg   <= step_next;
                wait_reg   <= wait_next;
                target_reg <= target_next;
                floor_reg  <= floor_next;
                enable_reg <= enable_next;
                for (int k = 0; k < 4; k++) duty_reg[k] <= duty_next[k];
            end
        end
    end

    // A running sequence always belongs to an active command
    a_busy_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_IDLE) |-> active_reg)
        else $error("ramp or coast running without an active command");

    // Stopped means all channels off
    a_stop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_reg == CMD_STOP) |-> (!active_reg && duty_reg[0] == '0 &&
        duty_reg[1] == '0 && duty_reg[2] == '0 && duty_reg[3] == '0))
        else $error("stopped drive with a channel still on");

    // Coasting keeps every channel at zero
    a_coast_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_COAST) |-> (duty_reg[0] == '0 && duty_reg[1] == '0 &&
        duty_reg[2] == '0 && duty_reg[3] == '0))
        else $error("channel driven during coast");

    // A waiting input item is kept until it is processed
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !proc) |=> (in_valid_reg && $stable(in_command_reg) &&
        $stable(in_speed_reg) && $stable(in_opcode_reg)))
        else $error("pending input item lost or changed");

    // Drive state only moves when a result is produced
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!proc) |=> ($stable(phase_reg) && $stable(idle_reg) && $stable(check_reg)))
        else $error("drive state changed without a transaction");

endmodule

### verif/drive_duty_checker.sv
`timescale 1ns / 100ps
// Duty-stream checker: tracks drive state per transaction, predicts duties and compares.
module drive_duty_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [dcmss_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [0:0]                       s_tuser,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [dcmss_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [dcmss_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [dcmss_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                               fail_count,
    output int                               pending_count
);
    import dcmss_pkg::*;

    localparam int DW          = DUTY_BITS;
    localparam int FULL        = (1 << DW) - 1;
    localparam int N_STEPS     = 20;
    localparam int N_POINTS    = 20;
    localparam int MAX_REPORTS = 10;

    // Channel enables, bit 0 left fwd, 1 left rev, 2 right fwd, 3 right rev
    localparam logic [3:0] FWD_PAIRS  = 4'b0101;
    localparam logic [3:0] REV_PAIRS  = 4'b1010;
    localparam logic [3:0] LEFT_TURN  = 4'b0100;
    localparam logic [3:0] RIGHT_TURN = 4'b0001;

    typedef enum logic [1:0] {RAMP_IDLE, RAMP_COAST, RAMP_LEFT, RAMP_RIGHT} ramp_phase_t;

    typedef struct packed {
        logic [DW-1:0] duty_lf;
        logic [DW-1:0] duty_lr;
        logic [DW-1:0] duty_rf;
        logic [DW-1:0] duty_rr;
        logic          busy;
        logic          active;
        logic [2:0]    cmd;
    } duty_result_t;

    // Cosine ease 0.5*(1-cos(pi*k/20)) in Q1.16, truncated; last point is exactly one
    int unsigned cos_ease [N_POINTS] = '{
        403, 1603, 3571, 6258, 9597, 13507, 17891, 22642, 27641, 32768,
        37894, 42893, 47644, 52028, 55938, 59277, 61964, 63932, 65132, 65536
    };

    // Register copies
    logic [6:0]    floor_pct_r;
    logic [7:0]    step_ms_r;
    logic [7:0]    coast_ms_r;
    logic [11:0]   dm_timeout_r;
    logic [9:0]    dm_period_r;

    // Drive state
    logic [2:0]    drive_cmd_q;
    logic [7:0]    drive_speed_q;
    logic          running_q;
    logic [11:0]   idle_ms_q;
    logic [9:0]    check_ms_q;
    ramp_phase_t   phase_q;
    logic [4:0]    step_q;
    logic [7:0]    wait_q;
    logic [DW-1:0] duty_q [4];
    logic [DW-1:0] target_q;
    logic [DW-1:0] floor_q;
    logic [3:0]    enable_q;

    duty_result_t  pending_duties [$];
    int            mismatches = 0;

    function automatic logic [7:0] step_gap();
        return (step_ms_r == 8'd0) ? 8'd1 : step_ms_r;
    endfunction

    // Level of ramp step s: floor plus the eased share of the span
    function automatic logic [DW-1:0] eased_level(int unsigned s);
        int unsigned     k;
        longint unsigned span;
        k = (s * N_POINTS + N_STEPS - 1) / N_STEPS;
        if (k < 1) k = 1;
        if (k > N_POINTS) k = N_POINTS;
        span = longint'(target_q - floor_q) * cos_ease[k-1];
        return DW'(int'(floor_q) + int'(span >> 16));
    endfunction

    function automatic void put_pair(int first, logic [DW-1:0] lvl);
        duty_q[first]   = enable_q[first]   ? lvl : '0;
        duty_q[first+1] = enable_q[first+1] ? lvl : '0;
    endfunction

    function automatic void clear_duties();
        foreach (duty_q[i]) duty_q[i] = '0;
    endfunction

    function automatic void begin_ramp();
        step_q = 5'd1;
        put_pair(0, eased_level(1));
        phase_q = RAMP_LEFT;
        wait_q = step_gap();
    endfunction

    function automatic void halt_drive();
        running_q     = 1'b0;
        drive_cmd_q   = CMD_STOP;
        drive_speed_q = '0;
        phase_q       = RAMP_IDLE;
        wait_q        = '0;
        step_q        = '0;
        clear_duties();
    endfunction

    function automatic void apply_command(logic [2:0] cmd, logic [7:0] spd);
        logic [2:0] prev;
        int         sp;
        int         pct;
        int         floor_max;
        prev = drive_cmd_q;
        // Stop and unknown codes
        if (cmd == CMD_STOP || cmd > CMD_RIGHT) begin
            halt_drive();
            return;
        end
        idle_ms_q = '0;
        running_q = 1'b1;
        // Repeat at the same speed only feeds the deadman
        if (cmd == prev && spd == drive_speed_q) return;
        drive_cmd_q   = cmd;
        drive_speed_q = spd;
        if (cmd == CMD_FWD || cmd == CMD_REV) begin
            sp = (spd > 8'd100) ? 100 : int'(spd);
            target_q = DW'(sp * FULL / 100);
            enable_q = (cmd == CMD_FWD) ? FWD_PAIRS : REV_PAIRS;
        end else begin
            target_q = DW'(FULL);
            enable_q = (cmd == CMD_LEFT) ? LEFT_TURN : RIGHT_TURN;
        end
        pct = (floor_pct_r > 7'd100) ? 100 : int'(floor_pct_r);
        floor_max = pct * FULL / 100;
        floor_q = (int'(target_q) < floor_max) ? target_q : DW'(floor_max);
        // Zero target: outputs off at once, no ramp
        if (target_q == '0) begin
            clear_duties();
            phase_q = RAMP_IDLE;
            wait_q  = '0;
            step_q  = '0;
            return;
        end
        // Reversal: coast before the ramp unless the coast time is zero
        if (prev != CMD_STOP && prev != cmd) begin
            clear_duties();
            if (coast_ms_r != 8'd0) begin
                phase_q = RAMP_COAST;
                wait_q  = coast_ms_r;
                step_q  = '0;
                return;
            end
        end
        begin_ramp();
    endfunction

    function automatic void apply_tick();
        int period;
        period = (dm_period_r == 10'd0) ? 1 : int'(dm_period_r);
        if (idle_ms_q != 12'hFFF) idle_ms_q = idle_ms_q + 1'b1;
        // Advance the ramp when its wait runs out
        if (phase_q != RAMP_IDLE) begin
            if (wait_q != 8'd0) wait_q = wait_q - 1'b1;
            if (wait_q == 8'd0) begin
                case (phase_q)
                    RAMP_COAST: begin_ramp();
                    RAMP_LEFT: begin
                        put_pair(2, eased_level(int'(step_q)));
                        phase_q = RAMP_RIGHT;
                        wait_q  = step_gap();
                    end
                    RAMP_RIGHT: begin
                        if (step_q >= N_STEPS) begin
                            put_pair(0, target_q);
                            put_pair(2, target_q);
                            phase_q = RAMP_IDLE;
                            wait_q  = '0;
                        end else begin
                            step_q = step_q + 1'b1;
                            put_pair(0, eased_level(int'(step_q)));
                            phase_q = RAMP_LEFT;
                            wait_q  = step_gap();
                        end
                    end
                    default: ;
                endcase
            end
        end
        // Deadman check
        check_ms_q = check_ms_q + 1'b1;
        if (int'(check_ms_q) >= period) begin
            check_ms_q = '0;
            if (running_q && idle_ms_q >= dm_timeout_r) halt_drive();
        end
    endfunction

    always @(posedge aclk) begin : track_proc
        duty_result_t got;
        duty_result_t want;
        if (!aresetn) begin
            floor_pct_r   = 7'd65;
            step_ms_r     = 8'd15;
            coast_ms_r    = 8'd80;
            dm_timeout_r  = 12'd800;
            dm_period_r   = 10'd100;
            drive_cmd_q   = CMD_STOP;
            drive_speed_q = '0;
            running_q     = 1'b0;
            idle_ms_q     = '0;
            check_ms_q    = '0;
            phase_q       = RAMP_IDLE;
            step_q        = '0;
            wait_q        = '0;
            target_q      = '0;
            floor_q       = '0;
            enable_q      = '0;
            clear_duties();
            pending_duties.delete();
        end else begin
            // Register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    CFG_FLOOR_PCT: floor_pct_r  = cfg_wdata[6:0];
                    CFG_ACCEL:     step_ms_r    = cfg_wdata[7:0];
                    CFG_COAST:     coast_ms_r   = cfg_wdata[7:0];
                    CFG_DM_TMO:    dm_timeout_r = cfg_wdata[11:0];
                    CFG_DM_PERIOD: dm_period_r  = cfg_wdata[9:0];
                    default: ;
                endcase
            end
            // Compare an accepted result with the oldest prediction
            if (m_tvalid && m_tready) begin
                got.duty_lf = m_tdata[DW-1:0];
                got.duty_lr = m_tdata[2*DW-1:DW];
                got.duty_rf = m_tdata[3*DW-1:2*DW];
                got.duty_rr = m_tdata[4*DW-1:3*DW];
                got.busy    = m_tdata[4*DW];
                got.active  = m_tdata[4*DW+1];
                got.cmd     = m_tdata[4*DW+4:4*DW+2];
                if (pending_duties.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: result with no prediction pending: %p", $time, got);
                    mismatches++;
                end else begin
                    want = pending_duties.pop_front();
                    if (got != want) begin
                        if (mismatches < MAX_REPORTS)
                            $display({"%0t: duty mismatch\n",
                                      "  expected lf=%0d lr=%0d rf=%0d rr=%0d busy=%0b",
                                      " act=%0b cmd=%0d\n",
                                      "  actual   lf=%0d lr=%0d rf=%0d rr=%0d busy=%0b",
                                      " act=%0b cmd=%0d"}, $time,
                                     want.duty_lf, want.duty_lr, want.duty_rf,
                                     want.duty_rr, want.busy, want.active, want.cmd,
                                     got.duty_lf, got.duty_lr, got.duty_rf,
                                     got.duty_rr, got.busy, got.active, got.cmd);
                        mismatches++;
                    end
                end
            end
            // Predict the result of an accepted input transaction
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == OP_DRIVE) apply_command(s_tdata[2:0], s_tdata[10:3]);
                else apply_tick();
                want = '{duty_q[0], duty_q[1], duty_q[2], duty_q[3],
                         phase_q != RAMP_IDLE, running_q, drive_cmd_q};
                pending_duties.push_back(want);
            end
        end
        fail_count    <= mismatches;
        pending_count <= pending_duties.size();
    end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// Testbench top for the soft-start drive: clock, reset, stimulus phases and verdict.
module tb;
    import dcmss_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 3'd7;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int         fail_count;
    int         pending_count;
    int         cycle_count    = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    logic [2:0] last_cmd       = CMD_STOP;
    logic [7:0] last_speed     = '0;

    dc_motor_soft_start_drive i_dut (.*);
    drive_duty_checker        i_chk (.*);

    always #2 aclk = ~aclk;

    // Receiver stalls
    always @(posedge aclk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** dc_motor_soft_start_drive: FAILED **");
            $finish;
        end
    end

    // One input transaction, after an optional random gap
    task automatic send_item(logic op, logic [2:0] cmd, logic [7:0] spd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({spd, cmd});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 3'($urandom), 8'($urandom));
    endtask

    task automatic send_drive(logic [2:0] cmd, logic [7:0] spd);
        send_item(OP_DRIVE, cmd, spd);
        last_cmd   = cmd;
        last_speed = spd;
    endtask

    // Hold the input until every predicted result has been taken
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_config(logic [CFG_DATA_W-1:0] floor_pct, logic [CFG_DATA_W-1:0] accel,
                              logic [CFG_DATA_W-1:0] coast, logic [CFG_DATA_W-1:0] dm_tmo,
                              logic [CFG_DATA_W-1:0] dm_period);
        write_reg(CFG_FLOOR_PCT, floor_pct);
        write_reg(CFG_ACCEL, accel);
        write_reg(CFG_COAST, coast);
        write_reg(CFG_DM_TMO, dm_tmo);
        write_reg(CFG_DM_PERIOD, dm_period);
        cfg_valid <= 1'b0;
    endtask

    // Command followed by a run of ticks, long enough at times to finish ramps
    task automatic run_random(int n_items);
        int         sent;
        int         ticks;
        int         r;
        logic [2:0] cmd;
        logic [7:0] spd;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 75)      cmd = 3'($urandom_range(CMD_FWD, CMD_RIGHT));
            else if (r < 88) cmd = CMD_STOP;
            else             cmd = CMD_RIGHT + 3'($urandom_range(1, 3));
            r = $urandom_range(99);
            if (r < 35)      spd = 8'($urandom);
            else if (r < 55) spd = 8'($urandom_range(0, 100));
            else if (r < 70) spd = last_speed;
            else if (r < 82) spd = 8'd100;
            else if (r < 90) spd = 8'd0;
            else             spd = 8'($urandom_range(101, 255));
            if ($urandom_range(99) < 15) cmd = last_cmd;
            send_drive(cmd, spd);
            r = $urandom_range(99);
            if (r < 35)      ticks = $urandom_range(0, 4);
            else if (r < 75) ticks = $urandom_range(5, 40);
            else             ticks = $urandom_range(40, 200);
            // Keep the phase at its item budget
            if (ticks > n_items - sent - 1) ticks = n_items - sent - 1;
            repeat (ticks) send_tick();
            sent += ticks + 1;
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed items under the reset configuration
        send_tick();
        send_drive(CMD_FWD, 8'd255);
        send_tick();
        send_tick();
        send_drive(CMD_FWD, 8'd255);
        send_drive(CMD_FWD, 8'd100);
        send_drive(CMD_REV, 8'd0);
        send_tick();
        send_drive(CMD_REV, 8'd30);
        send_drive(CMD_FWD, 8'd30);
        send_tick();
        send_drive(CMD_LEFT, 8'd0);
        send_drive(CMD_RIGHT, 8'd200);
        send_drive(CMD_RIGHT + 3'd1, 8'd1);
        send_drive(CMD_RIGHT + 3'd2, 8'd128);
        send_drive(CMD_RIGHT + 3'd3, 8'd255);
        send_drive(CMD_RIGHT, 8'd9);
        send_drive(CMD_STOP, 8'd0);
        send_drive(CMD_STOP, 8'd77);
        send_drive(CMD_LEFT, 8'd255);
        repeat (3) send_tick();
        send_drive(CMD_FWD, 8'd0);
        send_tick();

        // Reset configuration, no idling
        run_random(120);
        settle();

        // Floor above full, zero step and coast, very short deadman
        set_config(12'd127, 12'd0, 12'd0, 12'd3, 12'd0);
        send_idle_pct = 72;
        run_random(150);
        settle();

        // Zero floor, fast ramp; pause mid-phase until all results are in
        set_config(12'd0, 12'd1, 12'd2, 12'd60, 12'd1);
        send_idle_pct  = 0;
        recv_stall_pct = 72;
        run_random(130);
        settle();
        run_random(130);
        settle();

        // Full floor, longest coast and deadman limits
        set_config(12'd100, 12'd2, 12'd255, 12'd4095, 12'd1023);
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        run_random(150);
        settle();

        // Slowest stagger
        set_config(12'd35, 12'd255, 12'd1, 12'd40, 12'd9);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(120);
        settle();

        // Random register words, upper bits included, plus an unused index
        write_reg(CFG_SPARE, 12'($urandom));
        set_config(12'($urandom), 12'($urandom), 12'($urandom_range(0, 4095)),
                   12'($urandom_range(0, 300)), 12'($urandom_range(0, 40)));
        send_idle_pct = 72;
        run_random(150);
        settle();

        // Zero deadman timeout
        set_config(12'd50, 12'd1, 12'd0, 12'd0, 12'd5);
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        run_random(100);
        settle();

        // Silence after a command: the deadman must trip
        set_config(12'd20, 12'd1, 12'd0, 12'd40, 12'd9);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_drive(CMD_FWD, 8'd80);
        repeat (60) send_tick();
        settle();

        if (fail_count == 0) begin
            $display("** dc_motor_soft_start_drive: PASSED **");
        end else begin
            $display("** dc_motor_soft_start_drive: FAILED **");
        end
        $finish;
    end

endmodule
